// ===== sv/four_level_page_walker_unit_assert.svh =====
// assertion macros for the page walker
`ifndef FOUR_LEVEL_PAGE_WALKER_UNIT_ASSERT_SVH
`define FOUR_LEVEL_PAGE_WALKER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define PW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define PW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== sv/fpw_pkg.sv =====
package fpw_pkg;
    localparam int VA_W = 48;
    localparam int TB_W = 52;
    localparam int PG_W = 40;
    localparam int SKIP_W = 40;
    localparam int IDX_W = 9;

    typedef enum logic [1:0] {
        OP_XLATE = 2'd0,
        OP_FILL  = 2'd1,
        OP_FAIL  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    localparam logic [2:0] PROT_NONE = 3'd0;
    localparam logic [2:0] PROT_RO   = 3'd1;
    localparam logic [2:0] PROT_RW   = 3'd2;
    localparam logic [2:0] PROT_XR   = 3'd3;
    localparam logic [2:0] PROT_XRW  = 3'd4;

    localparam logic [2:0] NO_FAIL = 3'd4;

    // classified command from front to back
    typedef struct packed {
        op_t            op;
        logic [TB_W-1:0] table_base;
        logic [VA_W-1:0] virt_addr;
        logic [63:0]     fill_word;
        logic [IDX_W-1:0] fill_index;
        logic            fill_last;
    } cmd_t;

    typedef struct packed {
        logic            kind;
        logic [1:0]      lvl;
        logic [TB_W-1:0] fbase;
        logic            pres;
        logic [TB_W-1:0] pa;
        logic [2:0]      prot;
        logic [SKIP_W-1:0] skip;
    } res_t;

    function automatic logic [2:0] prot_code(input logic [63:0] e);
        logic rw;
        logic nx;
        rw = e[1];
        nx = e[63];
        if (!e[0] || !e[2]) return PROT_NONE;
        if (rw && !nx) return PROT_XRW;
        if (rw && nx) return PROT_RW;
        if (!rw && !nx) return PROT_XR;
        return PROT_RO;
    endfunction
endpackage

// ===== sv/fpw_front.sv =====
module fpw_front
    import fpw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic q_valid,
    input  logic q_ready,
    output cmd_t q_cmd
);
    // two-entry queue; unused op codes are dropped here
    cmd_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic push, pop, keep;

    assign keep = (in_cmd.op != OP_NONE);
    assign in_ready = (cnt_reg != 2'd2);
    assign push = in_valid && in_ready && keep;
    assign pop = q_valid && q_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wp_reg] <= in_cmd;
    end
endmodule

// ===== sv/fpw_back.sv =====
module fpw_back
    import fpw_pkg::*;
#(
    parameter int PHYS_ADDR_BITS = 52
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    output logic q_ready,
    input  cmd_t q_cmd,
    output logic r_valid,
    input  logic r_ready,
    output res_t r_data
);
    localparam logic [TB_W-1:0] PMASK = TB_W'((65'd1 << PHYS_ADDR_BITS) - 65'd1);
    localparam logic [TB_W-1:0] AMASK = PMASK & ~TB_W'(12'hFFF);

    typedef enum logic [1:0] { S_IDLE, S_READ, S_EVAL, S_OUT } state_t;

    state_t state_reg;
    logic [63:0] store_mem [4*512];
    logic [63:0] rd_reg;
    logic [TB_W-1:0] ctb_reg;
    logic [PG_W-1:0] pgb_reg [4];
    logic [3:0] valid_reg;
    logic pend_reg;
    logic [1:0] plvl_reg;
    logic [VA_W-1:0] va_reg;
    logic [1:0] lvl_reg;
    logic [2:0] fail_reg;
    logic [TB_W-1:0] base_reg;
    res_t res_reg;

    logic [5:0] shift;
    logic [IDX_W-1:0] idx;
    logic [PG_W-1:0] pg;
    logic [63:0] e;
    logic [VA_W:0] skip_full;
    logic [VA_W:0] va_hi;

    assign shift = 6'd39 - 6'(9 * lvl_reg);
    assign idx = IDX_W'(va_reg >> shift);
    assign pg = base_reg[TB_W-1:12];
    assign e = (fail_reg == {1'b0, lvl_reg}) ? 64'd0 : rd_reg;
    assign va_hi = {1'b0, va_reg} >> shift;
    assign skip_full = ((va_hi + 49'd1) << shift) - {1'b0, va_reg};

    assign q_ready = (state_reg == S_IDLE) && !r_valid;
    assign r_valid = (state_reg == S_OUT);
    assign r_data = res_reg;

    // table memory write path and registered read
    logic wr_en;
    logic [10:0] wr_addr, rd_addr;
    assign wr_en = (state_reg == S_IDLE) && q_valid && (q_cmd.op == OP_FILL) && pend_reg;
    assign wr_addr = {plvl_reg, q_cmd.fill_index};
    assign rd_addr = {lvl_reg, idx};

    always_ff @(posedge clk)
    begin
        if (wr_en) store_mem[wr_addr] <= q_cmd.fill_word;
        rd_reg <= store_mem[rd_addr];
    end

    // walk sequencer: one level per read/evaluate pair
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ctb_reg <= '0;
            valid_reg <= '0;
            pend_reg <= 1'b0;
            plvl_reg <= 2'd0;
            va_reg <= '0;
            lvl_reg <= 2'd0;
            fail_reg <= NO_FAIL;
            base_reg <= '0;
            for (int i = 0; i < 4; i++) pgb_reg[i] <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid && q_ready)
                    begin
                        lvl_reg <= 2'd0;
                        case (q_cmd.op)
                            OP_XLATE:
                            begin
                                if (q_cmd.table_base != ctb_reg) valid_reg <= '0;
                                ctb_reg <= q_cmd.table_base;
                                base_reg <= q_cmd.table_base & AMASK;
                                fail_reg <= NO_FAIL;
                                va_reg <= q_cmd.virt_addr;
                                pend_reg <= 1'b0;
                                state_reg <= S_READ;
                            end
                            OP_FILL:
                            begin
                                if (pend_reg && q_cmd.fill_last)
                                begin
                                    valid_reg[plvl_reg] <= 1'b1;
                                    base_reg <= ctb_reg & AMASK;
                                    fail_reg <= NO_FAIL;
                                    pend_reg <= 1'b0;
                                    state_reg <= S_READ;
                                end
                            end
                            OP_FAIL:
                            begin
                                if (pend_reg)
                                begin
                                    valid_reg[plvl_reg] <= 1'b0;
                                    base_reg <= ctb_reg & AMASK;
                                    fail_reg <= {1'b0, plvl_reg};
                                    pend_reg <= 1'b0;
                                    state_reg <= S_READ;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_READ:
                begin
                    // hit check; memory read address launches here
                    if (fail_reg != {1'b0, lvl_reg} &&
                        !(valid_reg[lvl_reg] && pgb_reg[lvl_reg] == pg))
                    begin
                        pgb_reg[lvl_reg] <= pg;
                        valid_reg[lvl_reg] <= 1'b0;
                        pend_reg <= 1'b1;
                        plvl_reg <= lvl_reg;
                        res_reg <= '{kind: 1'b0, lvl: lvl_reg, fbase: {pg, 12'h000},
                                     pres: 1'b0, pa: '0, prot: PROT_NONE, skip: '0};
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL:
                begin
                    if (!e[0])
                    begin
                        res_reg <= '{kind: 1'b1, lvl: 2'd0, fbase: '0, pres: 1'b0, pa: '0,
                                     prot: PROT_NONE,
                                     skip: (lvl_reg == 2'd3) ? SKIP_W'(4096)
                                                             : SKIP_W'(skip_full)};
                        state_reg <= S_OUT;
                    end
                    else if (lvl_reg == 2'd1 && e[7])
                    begin
                        res_reg <= '{kind: 1'b1, lvl: 2'd0, fbase: '0, pres: 1'b1,
                                     pa: ((e[TB_W-1:0] & PMASK & {22'h3FFFFF, 30'd0})
                                          | TB_W'(va_reg[29:0])),
                                     prot: prot_code(e), skip: SKIP_W'(1) << 30};
                        state_reg <= S_OUT;
                    end
                    else if (lvl_reg == 2'd2 && e[7])
                    begin
                        res_reg <= '{kind: 1'b1, lvl: 2'd0, fbase: '0, pres: 1'b1,
                                     pa: ((e[TB_W-1:0] & PMASK & {31'h7FFFFFFF, 21'd0})
                                          | TB_W'(va_reg[20:0])),
                                     prot: prot_code(e), skip: SKIP_W'(1) << 21};
                        state_reg <= S_OUT;
                    end
                    else if (lvl_reg == 2'd3)
                    begin
                        res_reg <= '{kind: 1'b1, lvl: 2'd0, fbase: '0, pres: 1'b1,
                                     pa: ((e[TB_W-1:0] & AMASK) | TB_W'(va_reg[11:0])),
                                     prot: prot_code(e), skip: SKIP_W'(4096)};
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        base_reg <= e[TB_W-1:0] & AMASK;
                        lvl_reg <= lvl_reg + 2'd1;
                        state_reg <= S_READ;
                    end
                end
                S_OUT:
                begin
                    if (r_ready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== sv/four_level_page_walker_unit.sv =====
// four-level page walker: a translate item walks up to four cached table
// pages, each level a memory read state then an evaluate state, after the
// idle state takes the item and before the output state hands out the
// result. A level miss goes from its read state straight to the output state,
// emits one fetch result (result_kind 0), and the walk restarts from the top
// after the last fill word or a fetch-failed item; other fill words leave the
// walker idle. A two-entry queue before the walker registers each item.
`include "four_level_page_walker_unit_assert.svh"
module four_level_page_walker_unit
    import fpw_pkg::*;
#(
    parameter int PHYS_ADDR_BITS = 52
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    input  logic [1:0] s_axis_tuser,    // operation
    input  logic s_axis_tlast,          // fill_last
    // table_base[51:0], virt_addr[99:52], fill_word[163:100], fill_index[172:164]
    input  logic [175:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    output logic m_axis_tuser,          // result_kind
    // fetch_level[1:0], fetch_base[53:2], present[54], phys_addr[106:55],
    // protection[109:107], skip_size[149:110]
    output logic [151:0] m_axis_tdata
);
    cmd_t in_cmd, q_cmd;
    res_t r_data;
    logic q_valid, q_ready;

    always_comb
    begin
        in_cmd.op = op_t'(s_axis_tuser);
        in_cmd.table_base = s_axis_tdata[51:0];
        in_cmd.virt_addr = s_axis_tdata[99:52];
        in_cmd.fill_word = s_axis_tdata[163:100];
        in_cmd.fill_index = s_axis_tdata[172:164];
        in_cmd.fill_last = s_axis_tlast;
    end

    fpw_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd(in_cmd),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    fpw_back #(.PHYS_ADDR_BITS(PHYS_ADDR_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .r_valid(m_axis_tvalid), .r_ready(m_axis_tready), .r_data(r_data)
    );

    assign m_axis_tuser = r_data.kind;
    assign m_axis_tdata = {2'b00, r_data.skip, r_data.prot, r_data.pa, r_data.pres,
                           r_data.fbase, r_data.lvl};

    // checks
    `PW_ASSERT_IMP(a_fetch_clean, clk, rst_n, m_axis_tvalid && !m_axis_tuser,
        m_axis_tdata[54] == 1'b0, "fetch result marked present")
    `PW_ASSERT_IMP(a_skip_nonzero, clk, rst_n, m_axis_tvalid && m_axis_tuser,
        m_axis_tdata[149:110] != 40'd0, "finished walk with zero skip")
    `PW_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "result dropped while stalled")
endmodule

// ===== test/four_level_page_walker_unit_test.sv =====
module four_level_page_walker_unit_test;
    import fpw_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 20;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [1:0] s_axis_tuser;    // operation
    logic s_axis_tlast;          // fill_last
    // table_base[51:0], virt_addr[99:52], fill_word[163:100], fill_index[172:164]
    logic [175:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic m_axis_tuser;          // result_kind
    // fetch_level[1:0], fetch_base[53:2], present[54], phys_addr[106:55],
    // protection[109:107], skip_size[149:110]
    logic [151:0] m_axis_tdata;

    four_level_page_walker_unit i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tdata(m_axis_tdata)
    );

    // walker state mirror
    bit [63:0] tbl_mem [4][512];
    bit [39:0] tbl_page [4];
    bit        tbl_ok [4];
    bit [51:0] root_base;
    bit        walk_busy;
    bit [1:0]  busy_lvl;
    bit [47:0] busy_va;
    res_t      walk_results [$];

    bit [39:0] page_pool [4];
    bit        idle_on;
    int        hold_req;
    int        quiet_cycles;
    int        errors;

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic bit [2:0] access_of(bit [63:0] e);
        if (!(e[0] && e[2]))
            return PROT_NONE;
        case ({e[63], e[1]})
            2'b01: return PROT_XRW;
            2'b11: return PROT_RW;
            2'b00: return PROT_XR;
            default: return PROT_RO;
        endcase
    endfunction

    // walk from the top; failed_lvl of 4 means no failed fetch
    task automatic walk_tables(int failed_lvl);
        bit [51:0] base;
        bit [63:0] e;
        bit [63:0] va64;
        bit [39:0] pg;
        int shift;
        int idx;
        res_t r;
        r = '0;
        r.kind = 1'b1;
        va64 = 64'(busy_va);
        base = {root_base[51:12], 12'h000};
        walk_busy = 1'b0;
        for (int lvl = 0; lvl < 4; lvl++)
        begin
            shift = 39 - 9 * lvl;
            idx = int'((va64 >> shift) & 64'h1FF);
            pg = base[51:12];
            if (lvl == failed_lvl)
                e = '0;
            else if (tbl_ok[lvl] && tbl_page[lvl] == pg)
                e = tbl_mem[lvl][idx];
            else
            begin
                tbl_page[lvl] = pg;
                tbl_ok[lvl] = 1'b0;
                walk_busy = 1'b1;
                busy_lvl = 2'(lvl);
                r.kind = 1'b0;
                r.lvl = 2'(lvl);
                r.fbase = {pg, 12'h000};
                walk_results.push_back(r);
                return;
            end
            if (!e[0])
            begin
                if (lvl == 3)
                    r.skip = 40'h1000;
                else
                    r.skip = 40'((((va64 >> shift) + 64'd1) << shift) - va64);
                walk_results.push_back(r);
                return;
            end
            if ((lvl == 1 || lvl == 2) && e[7] || lvl == 3)
            begin
                r.pres = 1'b1;
                r.prot = access_of(e);
                if (lvl == 1)
                begin
                    r.pa = {e[51:30], busy_va[29:0]};
                    r.skip = 40'd1 << 30;
                end
                else if (lvl == 2)
                begin
                    r.pa = {e[51:21], busy_va[20:0]};
                    r.skip = 40'd1 << 21;
                end
                else
                begin
                    r.pa = {e[51:12], busy_va[11:0]};
                    r.skip = 40'h1000;
                end
                walk_results.push_back(r);
                return;
            end
            base = {e[51:12], 12'h000};
        end
    endtask

    task automatic walker_step(op_t op, bit [51:0] tb, bit [47:0] va, bit [63:0] w,
                               bit [8:0] idx, bit last);
        if (op == OP_XLATE)
        begin
            if (tb != root_base)
            begin
                foreach (tbl_ok[i])
                    tbl_ok[i] = 1'b0;
                root_base = tb;
            end
            busy_va = va;
            walk_tables(4);
        end
        else if (walk_busy && op == OP_FILL)
        begin
            tbl_mem[busy_lvl][idx] = w;
            if (last)
            begin
                tbl_ok[busy_lvl] = 1'b1;
                walk_tables(4);
            end
        end
        else if (walk_busy && op == OP_FAIL)
        begin
            tbl_ok[busy_lvl] = 1'b0;
            walk_tables(int'(busy_lvl));
        end
    endtask

    // drive one item and wait until it is taken
    task automatic send_item(op_t op, bit [51:0] tb, bit [47:0] va, bit [63:0] w,
                             bit [8:0] idx, bit last);
        while (idle_on && $urandom_range(0, 99) < 18)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tlast <= last;
        s_axis_tdata <= {3'b000, idx, w, va, tb};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        walker_step(op, tb, va, w, idx, last);
    endtask

    task automatic send_xlate(bit [51:0] tb, bit [47:0] va);
        send_item(OP_XLATE, tb, va, '0, '0, 1'b0);
    endtask

    task automatic send_fill(bit [63:0] w, bit [8:0] idx, bit last);
        send_item(OP_FILL, '0, '0, w, idx, last);
    endtask

    task automatic send_fail();
        send_item(OP_FAIL, '0, '0, '0, '0, 1'b0);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (walk_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic bit [47:0] make_va(int i0, int i1, int i2, int i3, int off);
        return {9'(i0), 9'(i1), 9'(i2), 9'(i3), 12'(off)};
    endfunction

    // table index from the low or the high 64 entries, the ones preloaded
    function automatic int pick_index();
        if ($urandom_range(0, 1) == 0)
            return int'($urandom_range(0, 63));
        return int'($urandom_range(448, 511));
    endfunction

    // random entry, mostly pointing into a small set of pages
    function automatic bit [63:0] rand_entry(int lvl);
        bit [63:0] e;
        e = {$urandom, $urandom};
        if ($urandom_range(0, 3) != 0)
            e[51:12] = page_pool[$urandom_range(0, 3)];
        e[0] = ($urandom_range(0, 7) != 0);
        e[7] = (lvl == 1 || lvl == 2) && $urandom_range(0, 3) == 0;
        return e;
    endfunction

    // write the low and high 64 entries of all four levels once; every
    // address used later indexes only those, so no read sees unwritten data
    task automatic test_full_pages();
        bit [63:0] e;
        send_xlate({page_pool[0], 12'h000}, '0);
        for (int lvl = 0; lvl < 4; lvl++)
            for (int i = 0; i < 512; i++)
            begin
                if (i < 64 || i >= 448)
                begin
                    if (lvl < 3)
                        e = {12'h000, page_pool[lvl + 1], 12'h007};
                    else
                        e = rand_entry(3);
                    send_fill(e, 9'(i), i == 511);
                end
            end
    endtask

    task automatic test_directed();
        // ignored items
        send_item(OP_NONE, '1, '1, '1, '1, 1'b1);
        send_fill('1, '1, 1'b1);
        send_fail();
        // full cached walk, all-ones address
        send_xlate({page_pool[0], 12'h000}, '1);
        // new base, top level fetch fails
        send_xlate('1, '0);
        send_fail();
        // new base, top entry all ones, then a 1G leaf
        send_xlate({page_pool[0], 12'h000}, '0);
        send_fill('1, 9'd0, 1'b1);
        send_fill(64'h8000_0000_0000_0087 | {12'h000, 40'hABCDE_F0000, 12'h000}, 9'd0, 1'b1);
        // 2M leaf, exec-read
        send_xlate({page_pool[0], 12'h000}, make_va(0, 1, 0, 0, 12'h123));
        send_fill(64'h0000_0001_2340_0085, 9'd0, 1'b1);
        // 4K leaf read-only after a partial page
        send_xlate({page_pool[0], 12'h000}, make_va(0, 1, 1, 0, 12'hFFF));
        send_fill({$urandom, $urandom}, 9'd511, 1'b0);
        send_fill(64'h8000_0005_6789_A005, 9'd0, 1'b1);
        send_xlate({page_pool[0], 12'h000}, make_va(0, 1, 1, 0, 12'h001));
        // cached leaf hits; the supervisor and not-present leaf fills are ignored
        send_xlate({page_pool[0], 12'h000}, make_va(0, 1, 2, 0, 0));
        send_fill(64'h0000_0000_1111_1003, 9'd0, 1'b1);
        send_xlate({page_pool[0], 12'h000}, make_va(0, 1, 3, 0, 0));
        send_fill(64'h0000_0000_2222_2006, 9'd0, 1'b1);
        // level 3 hit, so the fail item is ignored, then an abandoned walk
        send_xlate({page_pool[0], 12'h000}, make_va(0, 1, 4, 7, 0));
        send_fail();
        send_xlate({page_pool[1], 12'h000}, make_va(5, 6, 7, 8, 9));
        send_xlate({page_pool[0], 12'h000}, make_va(0, 1, 1, 0, 12'h800));
        wait_drained();
    endtask

    task automatic test_random(int n_items);
        int done_items;
        int pick;
        bit [51:0] tb;
        done_items = 0;
        while (done_items < n_items)
        begin
            idle_on = !(done_items >= 200 && done_items < 400);
            if (done_items == 500)
                hold_req = 400;
            if (done_items == 650)
                wait_drained();
            pick = $urandom_range(0, 99);
            if (walk_busy && pick < 80)
                send_fill(rand_entry(int'(busy_lvl)), 9'($urandom), $urandom_range(0, 5) == 0);
            else if (walk_busy && pick < 88)
                send_fail();
            else if (pick < 95 || !walk_busy && pick < 85)
            begin
                tb = {page_pool[$urandom_range(0, 1)], 12'($urandom)};
                if ($urandom_range(0, 9) == 0)
                    tb = {$urandom, $urandom};
                send_xlate(tb, make_va(pick_index(), pick_index(), pick_index(),
                                       pick_index(), int'($urandom_range(0, 4095))));
            end
            else
            begin
                send_item(op_t'($urandom_range(1, 3)), {$urandom, $urandom},
                          {$urandom, $urandom}, {$urandom, $urandom}, 9'($urandom),
                          1'($urandom));
                continue;
            end
            done_items++;
        end
        wait_drained();
    endtask

    // receiver with random stalls and one long hold-off
    always @(posedge clk)
    begin
        if (hold_req > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_req <= hold_req - 1;
        end
        else
            m_axis_tready <= !(idle_on && $urandom_range(0, 99) < 18);
    end

    // result check
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (walk_results.size() == 0)
            begin
                $display("%0t: unexpected result kind %0d data %h", $time, m_axis_tuser,
                         m_axis_tdata);
                errors++;
            end
            else
            begin
                want = walk_results.pop_front();
                if (m_axis_tuser !== want.kind)
                begin
                    $display("%0t: result_kind exp %0d got %0d", $time, want.kind, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata[1:0] !== want.lvl)
                begin
                    $display("%0t: fetch_level exp %0d got %0d", $time, want.lvl,
                             m_axis_tdata[1:0]);
                    errors++;
                end
                if (m_axis_tdata[53:2] !== want.fbase)
                begin
                    $display("%0t: fetch_base exp %h got %h", $time, want.fbase,
                             m_axis_tdata[53:2]);
                    errors++;
                end
                if (m_axis_tdata[54] !== want.pres)
                begin
                    $display("%0t: present exp %0d got %0d", $time, want.pres, m_axis_tdata[54]);
                    errors++;
                end
                if (m_axis_tdata[106:55] !== want.pa)
                begin
                    $display("%0t: phys_addr exp %h got %h", $time, want.pa,
                             m_axis_tdata[106:55]);
                    errors++;
                end
                if (m_axis_tdata[109:107] !== want.prot)
                begin
                    $display("%0t: protection exp %0d got %0d", $time, want.prot,
                             m_axis_tdata[109:107]);
                    errors++;
                end
                if (m_axis_tdata[149:110] !== want.skip)
                begin
                    $display("%0t: skip_size exp %h got %h", $time, want.skip,
                             m_axis_tdata[149:110]);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no accepted item
    always @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready || m_axis_tvalid && m_axis_tready)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("four_level_page_walker_unit_test NOT OK");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = '0;
        s_axis_tlast = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        idle_on = 1'b1;
        hold_req = 0;
        quiet_cycles = 0;
        errors = 0;
        root_base = '0;
        walk_busy = 1'b0;
        busy_lvl = '0;
        busy_va = '0;
        foreach (tbl_ok[i])
        begin
            tbl_ok[i] = 1'b0;
            tbl_page[i] = '0;
        end
        page_pool[0] = 40'h00000_00100;
        page_pool[1] = 40'h00000_00200;
        page_pool[2] = 40'h00000_00300;
        page_pool[3] = 40'h00000_00400;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_full_pages();
        test_directed();
        test_random(750);
        if (errors == 0)
            $display("four_level_page_walker_unit_test OK");
        else
            $display("four_level_page_walker_unit_test NOT OK");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+sv
sv/fpw_pkg.sv
sv/fpw_front.sv
sv/fpw_back.sv
sv/four_level_page_walker_unit.sv
test/four_level_page_walker_unit_test.sv
